### rtl/lat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear array table package
// Shared sizes, request and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package lat_pkg;

   localparam int DEPTH   = 128;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int REQ_W   = 2;
   localparam int POS_W   = 8;
   localparam int STAT_W  = 2;
   localparam int WHERE_W = 7;
   localparam int COUNT_W = 8;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [REQ_W-1:0] {
      OP_INSERT  = 2'd0,
      OP_DEL_IDX = 2'd1,
      OP_DEL_VAL = 2'd2,
      OP_FIND    = 2'd3
   } req_op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE = 2'd0,
      ST_BAD  = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef struct packed {
      logic       load;
      logic       run_up;
      logic       run_down;
      logic       run_scan;
      logic       put;
      logic       inc_total;
      logic       dec_total;
      logic       rsp_load;
      status_type rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      req_op_type op;
      logic       ins_ok;
      logic       del_ok;
      logic       up_more;
      logic       down_more;
      logic       scan_more;
      logic       cmp_pending;
      logic       hit;
   } dp_stat_type;

endpackage
`default_nettype wire

### rtl/lat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/lat_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear array table datapath
// Entry memory, count, walk pointer, shift and scan pipelines, result regs.
// ----------------------------------------------------------------------------
module lat_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lat_pkg::dp_cmd_type         cmd,
   output lat_pkg::dp_stat_type             stat,
   input  wire logic [lat_pkg::REQ_W-1:0]   req_type,
   input  wire logic [lat_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [lat_pkg::WORD_W-1:0] req_data_word,
   output logic [lat_pkg::STAT_W-1:0]       rsp_status,
   output logic [lat_pkg::WHERE_W-1:0]      rsp_where_found,
   output logic [lat_pkg::COUNT_W-1:0]      rsp_entry_count
);
   import lat_pkg::*;

   req_op_type         op_ff, op_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [IDX_W-1:0]   where_ff, where_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [WHERE_W-1:0] rwhere_ff, rwhere_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [CNT_W-1:0]   ptr_dec;
   logic [CNT_W-1:0]   ptr_inc;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   total_ext;
   logic [CMP_W-1:0]   ptr_ext;
   logic               up_more;
   logic               down_more;
   logic               scan_more;
   logic               hit;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]  ram_rd_data;

   assign ptr_dec   = ptr_ff - 1'b1;
   assign ptr_inc   = ptr_ff + 1'b1;
   assign pos_ext   = CMP_W'(pos_ff);
   assign total_ext = CMP_W'(total_ff);
   assign ptr_ext   = CMP_W'(ptr_ff);
   assign up_more   = ptr_ext > pos_ext;
   assign down_more = ptr_inc < total_ff;
   assign scan_more = ptr_ff < total_ff;
   assign hit       = cmp_valid_ff && (ram_rd_data == word_ff);

   assign stat.op          = op_ff;
   assign stat.ins_ok      = (total_ff < CNT_W'(DEPTH)) && (pos_ext <= total_ext);
   assign stat.del_ok      = pos_ext < total_ext;
   assign stat.up_more     = up_more;
   assign stat.down_more   = down_more;
   assign stat.scan_more   = scan_more;
   assign stat.cmp_pending = cmp_valid_ff;
   assign stat.hit         = hit;

   always_comb begin
      ram_rd_en = cmd.run_up | cmd.run_down | cmd.run_scan;
      if (cmd.run_up) begin
         ram_rd_addr = ptr_dec[IDX_W-1:0];
      end else if (cmd.run_down) begin
         ram_rd_addr = ptr_inc[IDX_W-1:0];
      end else begin
         ram_rd_addr = ptr_ff[IDX_W-1:0];
      end
      ram_wr_en   = wr_pend_ff | cmd.put;
      ram_wr_addr = wr_pend_ff ? wr_addr_ff : pos_ext[IDX_W-1:0];
      ram_wr_data = wr_pend_ff ? ram_rd_data : word_ff;
   end

   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      total_in     = total_ff;
      ptr_in       = ptr_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      where_in     = where_ff;
      status_in    = status_ff;
      rwhere_in    = rwhere_ff;
      count_in     = count_ff;

      if (cmd.load) begin
         op_in    = req_op_type'(req_type);
         pos_in   = req_position;
         word_in  = req_data_word;
         where_in = '0;
         case (req_op_type'(req_type))
            OP_INSERT:  ptr_in = total_ff;
            OP_DEL_IDX: ptr_in = CNT_W'(req_position);
            default:    ptr_in = '0;
         endcase
      end

      // shift up: read below, write one above next cycle
      if (cmd.run_up && up_more) begin
         wr_pend_in = 1'b1;
         wr_addr_in = ptr_ff[IDX_W-1:0];
         ptr_in     = ptr_dec;
      end

      // shift down: read above, write one below next cycle
      if (cmd.run_down && down_more) begin
         wr_pend_in = 1'b1;
         wr_addr_in = ptr_ff[IDX_W-1:0];
         ptr_in     = ptr_inc;
      end

      if (cmd.run_scan) begin
         if (hit) begin
            where_in = cmp_idx_ff;
            ptr_in   = CNT_W'(cmp_idx_ff);
         end else if (scan_more) begin
            cmp_valid_in = 1'b1;
            cmp_idx_in   = ptr_ff[IDX_W-1:0];
            ptr_in       = ptr_inc;
         end
      end

      if (cmd.inc_total) begin
         total_in = total_ff + 1'b1;
      end else if (cmd.dec_total) begin
         total_in = total_ff - 1'b1;
      end

      if (cmd.rsp_load) begin
         status_in = cmd.rsp_status;
         rwhere_in = WHERE_W'(where_ff);
         count_in  = COUNT_W'(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         total_ff     <= total_in;
         cmp_valid_ff <= cmp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         ptr_ff       <= ptr_in;
      end
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      word_ff    <= word_in;
      cmp_idx_ff <= cmp_idx_in;
      wr_addr_ff <= wr_addr_in;
      where_ff   <= where_in;
      status_ff  <= status_in;
      rwhere_ff  <= rwhere_in;
      count_ff   <= count_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_where_found = rwhere_ff;
   assign rsp_entry_count = count_ff;

   lat_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

### rtl/lat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear array table controller
// Sequences dispatch, shift, scan and result hand-off for one request.
// ----------------------------------------------------------------------------
module lat_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lat_pkg::dp_cmd_type      cmd,
   input  wire lat_pkg::dp_stat_type stat
);
   import lat_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP,
      S_PUT,
      S_DOWN,
      S_SCAN,
      S_DONE
   } state_type;

   state_type  state_ff;
   logic       stall_ff;
   logic       rsp_valid_ff;
   status_type code_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stall_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == S_IDLE) && req_valid;
      cmd.run_up     = state_ff == S_UP;
      cmd.run_down   = state_ff == S_DOWN;
      cmd.run_scan   = state_ff == S_SCAN;
      cmd.put        = state_ff == S_PUT;
      cmd.inc_total  = state_ff == S_PUT;
      cmd.dec_total  = (state_ff == S_DOWN) && !stat.down_more;
      cmd.rsp_load   = (state_ff == S_DONE) && out_free;
      cmd.rsp_status = code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stall_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         code_ff      <= ST_DONE;
      end else begin
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DISPATCH;
                  stall_ff <= 1'b1;
                  code_ff  <= ST_DONE;
               end
            end
            S_DISPATCH: begin
               case (stat.op)
                  OP_INSERT: begin
                     if (stat.ins_ok) begin
                        state_ff <= S_UP;
                     end else begin
                        code_ff  <= ST_BAD;
                        state_ff <= S_DONE;
                     end
                  end
                  OP_DEL_IDX: begin
                     if (stat.del_ok) begin
                        state_ff <= S_DOWN;
                     end else begin
                        code_ff  <= ST_BAD;
                        state_ff <= S_DONE;
                     end
                  end
                  default: state_ff <= S_SCAN;
               endcase
            end
            S_UP: begin
               if (!stat.up_more) begin
                  state_ff <= S_PUT;
               end
            end
            S_PUT: state_ff <= S_DONE;
            S_DOWN: begin
               if (!stat.down_more) begin
                  state_ff <= S_DONE;
               end
            end
            S_SCAN: begin
               if (stat.hit) begin
                  state_ff <= (stat.op == OP_DEL_VAL) ? S_DOWN : S_DONE;
               end else if (!stat.scan_more && !stat.cmp_pending) begin
                  code_ff  <= ST_MISS;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  stall_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/linear_array_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear array table unit
// Packed list of signed words with insert, delete and find requests.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; the entry memory is walked one entry per
// cycle through its single read port and single write port.
// Reset clears the entry count and all control state; memory is not cleared.
// ----------------------------------------------------------------------------
module linear_array_table_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [lat_pkg::REQ_W-1:0]   req_type,
   input  wire logic [lat_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [lat_pkg::WORD_W-1:0] req_data_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lat_pkg::STAT_W-1:0]       rsp_status,
   output logic [lat_pkg::WHERE_W-1:0]      rsp_where_found,
   output logic [lat_pkg::COUNT_W-1:0]      rsp_entry_count
);
   import lat_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   lat_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_data_word   (req_data_word),
      .rsp_status      (rsp_status),
      .rsp_where_found (rsp_where_found),
      .rsp_entry_count (rsp_entry_count)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but unit not busy");

   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_BAD || rsp_status == ST_MISS))
         |-> (rsp_where_found == '0))
      else $error("failed request reports a nonzero index");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a request in progress");

   a_no_put_and_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !(cmd.run_up || cmd.run_down || cmd.run_scan))
      else $error("insert write overlaps a memory walk");

endmodule
`default_nettype wire
